// ===== src/qualified_running_mean_unit_defines.svh =====
// Assertion macros for the qualified running mean unit
`ifndef QUALIFIED_RUNNING_MEAN_UNIT_DEFINES_SVH
`define QUALIFIED_RUNNING_MEAN_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define QRM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrm: same-cycle implication violated");
`define QRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrm: next-cycle implication violated");
`else
`define QRM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define QRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/qrm_pkg.sv =====
package qrm_pkg;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int RATIO_BITS = 16;
   localparam int DIV_BITS   = VALUE_BITS + 1;
   localparam int STEP_BITS  = $clog2(DIV_BITS);
   localparam int PROD_BITS  = COUNT_BITS + RATIO_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = RATIO_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREEZE_MODE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ERROR_RATIO = 1'b1;

   localparam logic [RATIO_BITS-1:0] ERROR_RATIO_RESET = RATIO_BITS'(128);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX         = '1;
   localparam logic [STEP_BITS-1:0]  DIV_LAST_STEP     = STEP_BITS'(DIV_BITS - 1);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sample;
      logic                         sample_unreliable;
      logic                         sample_off_scan;
      logic                         period_reset;
   } qrm_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] published_value;
      logic                         published_unreliable;
      logic signed [VALUE_BITS-1:0] current_mean;
      logic [COUNT_BITS-1:0]        error_tally;
   } qrm_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_CHECK,
      S_DIV,
      S_FIX,
      S_DONE
   } qrm_state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic check;
      logic div_step;
      logic fix;
      logic load_out;
   } qrm_cmd_type;

   typedef struct packed {
      logic bad;
      logic over_limit;
      logic div_last;
      logic out_free;
   } qrm_sts_type;

endpackage

// ===== src/qrm_ctrl.sv =====
module qrm_ctrl
   import qrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  qrm_sts_type sts,
   output qrm_cmd_type cmd
);

   qrm_state_type state_ff;
   qrm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (sts.bad || sts.over_limit) ? S_DONE : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/qrm_dpath.sv =====
module qrm_dpath
   import qrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  qrm_cmd_type           cmd,
   output qrm_sts_type           sts,
   input  qrm_req_type           req_data,
   input  logic                  freeze_mode,
   input  logic [RATIO_BITS-1:0] error_ratio,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qrm_rsp_type           rsp_data
);

   logic signed [VALUE_BITS-1:0] sample_ff;
   logic                         bad_ff;
   logic                         expired_ff;

   logic signed [VALUE_BITS-1:0] mean_ff;
   logic [COUNT_BITS-1:0]        tally_ff;
   logic [COUNT_BITS-1:0]        err_ff;
   logic                         held_ff;
   logic signed [VALUE_BITS-1:0] shown_value_ff;
   logic                         shown_flag_ff;

   logic [PROD_BITS-1:0]         prod_ff;
   logic                         neg_ff;
   logic [DIV_BITS-1:0]          quot_ff;
   logic [COUNT_BITS-1:0]        rem_ff;
   logic [STEP_BITS-1:0]         step_ff;

   logic                         rsp_valid_ff;
   qrm_rsp_type                  rsp_data_ff;

   logic signed [VALUE_BITS-1:0] mean_base;
   logic [COUNT_BITS-1:0]        tally_base;
   logic [COUNT_BITS-1:0]        err_base;
   logic [COUNT_BITS-1:0]        tally_new;
   logic [COUNT_BITS-1:0]        err_new;
   logic signed [DIV_BITS-1:0]   diff;
   logic [DIV_BITS-1:0]          diff_mag;
   logic [PROD_BITS-1:0]         err_scaled;
   logic                         over;
   logic [COUNT_BITS:0]          rem_shift;
   logic [COUNT_BITS+1:0]        trial;
   logic                         q_bit;
   logic [COUNT_BITS-1:0]        rem_next;
   logic [DIV_BITS-1:0]          qmag;
   logic signed [DIV_BITS:0]     delta;
   logic signed [DIV_BITS:0]     mean_sum;
   logic signed [VALUE_BITS-1:0] mean_new;

   always_comb begin
      mean_base  = expired_ff ? '0 : mean_ff;
      tally_base = expired_ff ? '0 : tally_ff;
      err_base   = expired_ff ? '0 : err_ff;
      tally_new  = (tally_base == COUNT_MAX) ? tally_base : tally_base + COUNT_BITS'(1);
      err_new    = (bad_ff && err_base != COUNT_MAX) ? err_base + COUNT_BITS'(1) : err_base;
      diff       = {sample_ff[VALUE_BITS-1], sample_ff} - {mean_base[VALUE_BITS-1], mean_base};
      diff_mag   = diff[DIV_BITS-1] ? DIV_BITS'(-diff) : DIV_BITS'(diff);

      err_scaled = PROD_BITS'({err_ff, 8'b0});
      over       = err_scaled >= prod_ff;

      rem_shift  = {rem_ff, quot_ff[DIV_BITS-1]};
      trial      = {1'b0, rem_shift} - {2'b00, tally_ff};
      q_bit      = !trial[COUNT_BITS+1];
      rem_next   = q_bit ? trial[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];

      qmag       = quot_ff + DIV_BITS'(neg_ff && rem_ff != '0);
      delta      = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      mean_sum   = {{2{mean_ff[VALUE_BITS-1]}}, mean_ff} + delta;
      mean_new   = mean_sum[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff  <= req_data.sample;
         bad_ff     <= req_data.sample_unreliable | req_data.sample_off_scan;
         expired_ff <= req_data.period_reset;
      end
      if (cmd.prep) begin
         prod_ff <= PROD_BITS'(tally_new) * PROD_BITS'(error_ratio);
         neg_ff  <= diff[DIV_BITS-1];
         quot_ff <= diff_mag;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[DIV_BITS-2:0], q_bit};
         rem_ff  <= rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff        <= '0;
         tally_ff       <= '0;
         err_ff         <= '0;
         held_ff        <= 1'b0;
         shown_value_ff <= '0;
         shown_flag_ff  <= 1'b0;
         step_ff        <= '0;
      end else begin
         if (cmd.prep) begin
            tally_ff <= tally_new;
            err_ff   <= err_new;
            mean_ff  <= mean_base;
            step_ff  <= '0;
            if (expired_ff) begin
               shown_value_ff <= freeze_mode ? mean_ff : '0;
               shown_flag_ff  <= freeze_mode ? held_ff : 1'b0;
            end
         end
         if (cmd.check && !bad_ff && over) begin
            if (freeze_mode) begin
               held_ff <= 1'b1;
            end else begin
               shown_flag_ff <= 1'b1;
            end
         end
         if (cmd.div_step) begin
            step_ff <= step_ff + STEP_BITS'(1);
         end
         if (cmd.fix) begin
            mean_ff <= mean_new;
            if (freeze_mode) begin
               held_ff <= 1'b0;
            end else begin
               shown_value_ff <= mean_new;
               shown_flag_ff  <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.published_value      <= shown_value_ff;
         rsp_data_ff.published_unreliable <= shown_flag_ff;
         rsp_data_ff.current_mean         <= mean_ff;
         rsp_data_ff.error_tally          <= err_ff;
      end
   end

   assign sts.bad        = bad_ff;
   assign sts.over_limit = over;
   assign sts.div_last   = step_ff == DIV_LAST_STEP;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/qualified_running_mean_unit.sv =====
// A beat is taken in S_IDLE and passes S_PREP and S_CHECK; a flagged or refused sample then goes
//   to S_DONE, while a mean update first runs a 33-step serial restoring divider and S_FIX.
// No new beat is taken until S_DONE, which waits for a free output register, has loaded the result.
// A finished result waits in an output register while the next beat is taken.
// Reset (synchronous, active high) clears mean, counters, flags, output valid;
//   freeze_mode returns to 0 and error_ratio to 128.
`include "qualified_running_mean_unit_defines.svh"

module qualified_running_mean_unit
   import qrm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  qrm_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output qrm_rsp_type               rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                  freeze_ff;
   logic [RATIO_BITS-1:0] ratio_ff;
   qrm_cmd_type           cmd;
   qrm_sts_type           sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         freeze_ff <= 1'b0;
         ratio_ff  <= ERROR_RATIO_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FREEZE_MODE: freeze_ff <= csr_wdata[0];
            CSR_ERROR_RATIO: ratio_ff  <= csr_wdata[RATIO_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   qrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qrm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .freeze_mode (freeze_ff),
      .error_ratio (ratio_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `QRM_ASSERT_IMPLY(a_load_needs_slot, clock, reset, cmd.load_out, sts.out_free)
   `QRM_ASSERT_NEXT(a_one_beat_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `QRM_ASSERT_IMPLY(a_rsp_from_load, clock, reset, $rose(rsp_valid), $past(cmd.load_out))

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qrm_pkg::*;

   localparam logic signed [VALUE_BITS-1:0] SAMPLE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] SAMPLE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] UNIT       = VALUE_BITS'(1) << 16;
   localparam int DRAIN_CYCLES = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   qrm_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   qrm_rsp_type               rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_FREEZE_MODE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   qrm_req_type sample_beats[$];
   qrm_rsp_type awaited_publications[$];
   int          send_gap = 0;
   int          take_gap = 0;
   bit          no_idle = 1'b0;
   int          failures = 0;

   logic                         freeze_q = 1'b0;
   logic [RATIO_BITS-1:0]        ratio_q = ERROR_RATIO_RESET;
   logic signed [VALUE_BITS-1:0] mean_q = '0;
   logic signed [VALUE_BITS-1:0] shown_q = '0;
   logic [COUNT_BITS-1:0]        samples_q = '0;
   logic [COUNT_BITS-1:0]        errors_q = '0;
   logic                         held_q = 1'b0;
   logic                         shown_flag_q = 1'b0;

   qualified_running_mean_unit uut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("qualified_running_mean_unit verification failed");
      $finish;
   end

   function automatic void publish_running_mean(qrm_req_type b);
      qrm_rsp_type r;
      longint      delta;
      longint      step;
      longint      n;
      if (b.period_reset) begin
         samples_q = '0;
         errors_q  = '0;
         if (freeze_q) begin
            shown_q      = mean_q;
            shown_flag_q = held_q;
         end else begin
            shown_q      = '0;
            shown_flag_q = 1'b0;
         end
         mean_q = '0;
      end
      if (samples_q != COUNT_MAX) samples_q++;
      if (b.sample_unreliable || b.sample_off_scan) begin
         if (errors_q != COUNT_MAX) errors_q++;
      end else if ((longint'(errors_q) << 8) >= longint'(samples_q) * longint'(ratio_q)) begin
         if (freeze_q) held_q = 1'b1;
         else shown_flag_q = 1'b1;
      end else begin
         n     = longint'(samples_q);
         delta = longint'(b.sample) - longint'(mean_q);
         if (delta >= 0) step = delta / n;
         else step = -((-delta + n - 1) / n);
         mean_q = VALUE_BITS'(longint'(mean_q) + step);
         if (freeze_q) begin
            held_q = 1'b0;
         end else begin
            shown_q      = mean_q;
            shown_flag_q = 1'b0;
         end
      end
      r.published_value      = shown_q;
      r.published_unreliable = shown_flag_q;
      r.current_mean         = mean_q;
      r.error_tally          = errors_q;
      awaited_publications.push_back(r);
   endfunction

   function automatic void queue_beat(logic signed [VALUE_BITS-1:0] value, bit unreliable,
                                      bit off_scan, bit expire);
      qrm_req_type b;
      b.sample            = value;
      b.sample_unreliable = unreliable;
      b.sample_off_scan   = off_scan;
      b.period_reset      = expire;
      sample_beats.push_back(b);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return VALUE_BITS'($urandom_range(0, 32'h0004_0000)) - (UNIT << 1);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   task automatic compare_field(string label, longint want, longint got);
      if (want != got) begin
         failures++;
         $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_FREEZE_MODE) freeze_q = value[0];
      else if (index == CSR_ERROR_RATIO) ratio_q = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (sample_beats.size() != 0 || req_valid || awaited_publications.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // driver: present the next beat once the previous one is taken and its gap has run out
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            publish_running_mean(req_data);
            send_gap = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_beats.size() != 0) begin
               req_data  <= sample_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest expected publication
   always @(posedge clock) begin
      qrm_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            take_gap = no_idle ? 0 : $urandom_range(0, 9);
            if (awaited_publications.size() == 0) begin
               failures++;
               $display("%0t: result beat expected none, actual %p", $time, rsp_data);
            end else begin
               want = awaited_publications.pop_front();
               compare_field("published_value", want.published_value,
                             rsp_data.published_value);
               compare_field("published_unreliable", want.published_unreliable,
                             rsp_data.published_unreliable);
               compare_field("current_mean", want.current_mean, rsp_data.current_mean);
               compare_field("error_tally", want.error_tally, rsp_data.error_tally);
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int                       kind;
      logic [CSR_DATA_BITS-1:0] mode_word;
      logic [RATIO_BITS-1:0]    ratio;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // live mode, default ratio: extremes, each flag, exact threshold, period end
      queue_beat(SAMPLE_MAX, 1'b0, 1'b0, 1'b0);
      queue_beat(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
      queue_beat(-1, 1'b1, 1'b0, 1'b0);
      queue_beat(UNIT * 5, 1'b0, 1'b1, 1'b0);
      queue_beat(7, 1'b1, 1'b1, 1'b0);
      queue_beat(UNIT * 3, 1'b0, 1'b0, 1'b0);
      queue_beat(-UNIT * 3, 1'b0, 1'b0, 1'b1);
      queue_beat(-5, 1'b0, 1'b0, 1'b0);
      drain();

      // freeze mode: refuse a clean sample, then publish the held flag at period end
      write_csr(CSR_FREEZE_MODE, CSR_DATA_BITS'(1));
      queue_beat(UNIT * 2, 1'b0, 1'b0, 1'b1);
      queue_beat(SAMPLE_MAX, 1'b1, 1'b0, 1'b0);
      queue_beat(SAMPLE_MIN, 1'b0, 1'b1, 1'b0);
      queue_beat(UNIT, 1'b0, 1'b0, 1'b0);
      queue_beat(-UNIT, 1'b0, 1'b0, 1'b1);
      queue_beat(UNIT * 4, 1'b0, 1'b0, 1'b0);
      drain();

      // switch back to live mode inside a running period
      write_csr(CSR_FREEZE_MODE, CSR_DATA_BITS'(0));
      queue_beat(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
      queue_beat(UNIT, 1'b1, 1'b0, 1'b1);
      queue_beat(SAMPLE_MAX, 1'b0, 1'b0, 1'b0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ratio = ERROR_RATIO_RESET;
            1: ratio = '0;
            2: ratio = '1;
            3: ratio = RATIO_BITS'(256);
            4: ratio = RATIO_BITS'(1);
            default: ratio = RATIO_BITS'($urandom_range(2, 640));
         endcase
         mode_word    = CSR_DATA_BITS'($urandom);
         mode_word[0] = phase[0];
         write_csr(CSR_FREEZE_MODE, mode_word);
         write_csr(CSR_ERROR_RATIO, ratio);
         no_idle = (phase == 5);
         repeat (106) begin
            kind = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
            queue_beat(pick_sample(), kind[0], kind[1], $urandom_range(0, 11) == 0);
         end
         drain();
      end

      if (failures == 0) begin
         $display("qualified_running_mean_unit verification clean");
      end else begin
         $display("qualified_running_mean_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/qrm_pkg.sv
src/qrm_ctrl.sv
src/qrm_dpath.sv
src/qualified_running_mean_unit.sv
tb/sv/testbench.sv
